FILE: rtl/wsg_pkg.sv
// ----------------------------------------------------------------------------
// Waveform sample generator package
// Shared widths, codes, pipeline stage names and the sine table builder.
// ----------------------------------------------------------------------------
package wsg_pkg;

  // Fixed field widths
  localparam int TIME_BITS      = 32;
  localparam int REG_BITS       = 32;
  localparam int AMP_BITS       = 15;
  localparam int WF_BITS        = 2;
  localparam int CFG_ADDR_BITS  = 4;

  // Number formats
  localparam int PHASE_BITS      = 32;
  localparam int SAMPLE_BITS     = 16;
  localparam int SINE_TABLE_BITS = 10;
  localparam int Q_FRAC          = 30;
  localparam int ENTRY_BITS      = Q_FRAC + 1;
  localparam int QW              = PHASE_BITS - 2;
  localparam int IDX_SHIFT       = QW - SINE_TABLE_BITS;
  localparam int IDX_BITS        = SINE_TABLE_BITS + 1;
  localparam int TAB_N           = 1 << SINE_TABLE_BITS;
  localparam int TRI_PROD_BITS   = AMP_BITS + QW + 2;
  localparam int SIN_PROD_BITS   = AMP_BITS + ENTRY_BITS + 1;
  localparam int SAMPLE_LIM      = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [TIME_BITS-1:0]          time_t;
  typedef logic [REG_BITS-1:0]           reg_t;
  typedef logic [AMP_BITS-1:0]           amp_t;
  typedef logic [PHASE_BITS-1:0]         phase_t;
  typedef logic [QW:0]                   qmag_t;
  typedef logic [IDX_BITS-1:0]           idx_t;
  typedef logic [ENTRY_BITS-1:0]         entry_t;
  typedef logic [TRI_PROD_BITS-1:0]      tri_prod_t;
  typedef logic [SIN_PROD_BITS-1:0]      sin_prod_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef entry_t                        sine_rom_t [0:TAB_N];

  localparam qmag_t     QUARTER   = qmag_t'(1) << QW;
  localparam qmag_t     IDX_HALF  = qmag_t'(1) << (IDX_SHIFT - 1);
  localparam tri_prod_t TRI_RND   = tri_prod_t'(1) << (QW - 1);
  localparam sin_prod_t SIN_RND   = sin_prod_t'(1) << (Q_FRAC - 1);
  localparam sample_t   SAMPLE_MIN = sample_t'(1) << (SAMPLE_BITS - 1);

  typedef enum logic [WF_BITS-1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_ZERO   = 2'd3
  } wave_t;

  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_PHASE_OFFSET = 2'd1,
    REG_AMPLITUDE    = 2'd2
  } reg_idx_t;

  // Pipeline stages
  localparam int NSTAGE = 6;
  localparam int ST_MUL = 0;  // time * step
  localparam int ST_PH  = 1;  // add offset
  localparam int ST_IDX = 2;  // fold quadrant, table index
  localparam int ST_ROM = 3;  // table read, triangle product
  localparam int ST_SCL = 4;  // sine product, triangle rounding
  localparam int ST_OUT = 5;  // select, clamp, sign

  typedef struct packed {
    reg_t phase_step;
    reg_t phase_offset;
    amp_t amplitude;
  } cfg_t;

  typedef struct packed {
    logic [NSTAGE-1:0] ld;   // stage register loads this cycle
    logic [NSTAGE-1:0] vld;  // stage register holds a beat
  } pipe_ctl_t;

  typedef struct packed {
    phase_t ph;
    wave_t  wf;
  } ph_out_t;

  typedef struct packed {
    sin_prod_t sin_prod;
    amp_t      tri_mag;
    logic      neg;
    wave_t     wf;
  } shp_out_t;

  // Quarter-wave sine in Q30, built by a truncated integer Taylor series.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t          rom;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] q_one;
    q_one = 64'sd1 <<< Q_FRAC;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      term = x;
      sum  = signed'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> Q_FRAC;
        term = ((term * x) >> Q_FRAC) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - signed'(term);
        end else begin
          sum = sum + signed'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > q_one) begin
        sum = q_one;
      end
      rom[k] = entry_t'(sum);
    end
    return rom;
  endfunction

endpackage

FILE: rtl/wsg_cfg.sv
// ----------------------------------------------------------------------------
// Waveform sample generator register file
// APB-style write and read access to phase step, phase offset and amplitude.
// ----------------------------------------------------------------------------
module wsg_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [wsg_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [wsg_pkg::REG_BITS-1:0]       cfg_pwdata,
  output logic [wsg_pkg::REG_BITS-1:0]       cfg_prdata,
  output logic                               cfg_pready,
  output wsg_pkg::cfg_t                      cfg
);

  wsg_pkg::cfg_t cfg_r;
  wsg_pkg::cfg_t cfg_nxt;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        wsg_pkg::REG_PHASE_STEP:   cfg_nxt.phase_step   = cfg_pwdata;
        wsg_pkg::REG_PHASE_OFFSET: cfg_nxt.phase_offset = cfg_pwdata;
        wsg_pkg::REG_AMPLITUDE:    cfg_nxt.amplitude    = cfg_pwdata[wsg_pkg::AMP_BITS-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      wsg_pkg::REG_PHASE_STEP:   cfg_prdata = cfg_r.phase_step;
      wsg_pkg::REG_PHASE_OFFSET: cfg_prdata = cfg_r.phase_offset;
      wsg_pkg::REG_AMPLITUDE:    cfg_prdata = wsg_pkg::REG_BITS'(cfg_r.amplitude);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/wsg_phase.sv
// ----------------------------------------------------------------------------
// Waveform sample generator phase stages
// Multiplies the sample time by the phase step, then adds the phase offset.
// ----------------------------------------------------------------------------
module wsg_phase (
  input  logic                  clk,
  input  wsg_pkg::pipe_ctl_t    ctl,
  input  wsg_pkg::cfg_t         cfg,
  input  wsg_pkg::time_t        time_ticks,
  input  wsg_pkg::wave_t        waveform,
  output wsg_pkg::ph_out_t      ph_out
);

  logic [63:0]     prod_full;
  wsg_pkg::phase_t prod_r;
  wsg_pkg::wave_t  wf_a_r;
  wsg_pkg::phase_t ph_r;
  wsg_pkg::wave_t  wf_b_r;

  assign prod_full = 64'(time_ticks) * 64'(cfg.phase_step);

  always_ff @(posedge clk) begin
    if (ctl.ld[wsg_pkg::ST_MUL]) begin
      prod_r <= wsg_pkg::phase_t'(prod_full);
      wf_a_r <= waveform;
    end
  end

  // Phase wraps modulo one full cycle by dropping the carry.
  always_ff @(posedge clk) begin
    if (ctl.ld[wsg_pkg::ST_PH]) begin
      ph_r   <= prod_r + wsg_pkg::phase_t'(cfg.phase_offset);
      wf_b_r <= wf_a_r;
    end
  end

  assign ph_out.ph = ph_r;
  assign ph_out.wf = wf_b_r;

endmodule

FILE: rtl/wsg_shape.sv
// ----------------------------------------------------------------------------
// Waveform sample generator shaping stages
// Folds the phase into one quarter, reads the sine table and scales by the
// amplitude for the sine and triangle shapes.
// ----------------------------------------------------------------------------
module wsg_shape (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wsg_pkg::pipe_ctl_t   ctl,
  input  wsg_pkg::cfg_t        cfg,
  input  wsg_pkg::ph_out_t     ph_in,
  output wsg_pkg::shp_out_t    shp_out
);

  localparam wsg_pkg::sine_rom_t SineRom = wsg_pkg::build_sine_rom();

  wsg_pkg::qmag_t      qm;
  wsg_pkg::qmag_t      idx_sum;
  wsg_pkg::idx_t       idx_full;
  wsg_pkg::idx_t       idx;

  wsg_pkg::qmag_t      qm_r;
  wsg_pkg::idx_t       idx_r;
  logic                neg_c_r;
  wsg_pkg::wave_t      wf_c_r;

  wsg_pkg::entry_t     entry_r;
  wsg_pkg::tri_prod_t  tri_prod_r;
  logic                neg_d_r;
  wsg_pkg::wave_t      wf_d_r;

  wsg_pkg::sin_prod_t  sin_prod_r;
  wsg_pkg::amp_t       tri_mag_r;
  logic                neg_e_r;
  wsg_pkg::wave_t      wf_e_r;

  // Odd quadrants run backward through the quarter. The folded value is also
  // the triangle's distance from zero.
  always_comb begin
    if (ph_in.ph[wsg_pkg::QW]) begin
      qm = wsg_pkg::QUARTER - {1'b0, ph_in.ph[wsg_pkg::QW-1:0]};
    end else begin
      qm = {1'b0, ph_in.ph[wsg_pkg::QW-1:0]};
    end
    idx_sum  = qm + wsg_pkg::IDX_HALF;
    idx_full = wsg_pkg::idx_t'(idx_sum >> wsg_pkg::IDX_SHIFT);
    if (idx_full > wsg_pkg::idx_t'(wsg_pkg::TAB_N)) begin
      idx = wsg_pkg::idx_t'(wsg_pkg::TAB_N);
    end else begin
      idx = idx_full;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[wsg_pkg::ST_IDX]) begin
      qm_r    <= qm;
      idx_r   <= idx;
      neg_c_r <= ph_in.ph[wsg_pkg::PHASE_BITS-1];
      wf_c_r  <= ph_in.wf;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[wsg_pkg::ST_ROM]) begin
      entry_r    <= SineRom[idx_r];
      tri_prod_r <= wsg_pkg::tri_prod_t'(cfg.amplitude) * wsg_pkg::tri_prod_t'(qm_r);
      neg_d_r    <= neg_c_r;
      wf_d_r     <= wf_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[wsg_pkg::ST_SCL]) begin
      sin_prod_r <= wsg_pkg::sin_prod_t'(cfg.amplitude) * wsg_pkg::sin_prod_t'(entry_r);
      tri_mag_r  <= wsg_pkg::amp_t'((tri_prod_r + wsg_pkg::TRI_RND) >> wsg_pkg::QW);
      neg_e_r    <= neg_d_r;
      wf_e_r     <= wf_d_r;
    end
  end

  assign shp_out.sin_prod = sin_prod_r;
  assign shp_out.tri_mag  = tri_mag_r;
  assign shp_out.neg      = neg_e_r;
  assign shp_out.wf       = wf_e_r;

`ifndef SYNTHESIS
  a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld[wsg_pkg::ST_IDX] |-> (idx_r <= wsg_pkg::idx_t'(wsg_pkg::TAB_N)))
    else $error("sine table index beyond the last entry");
`endif

endmodule

FILE: rtl/waveform_sample_generator_unit.sv
// ----------------------------------------------------------------------------
// Waveform sample generator
// Direct digital synthesis of sine, triangle and square samples, one per beat.
// ----------------------------------------------------------------------------
//
// Channel  Ports             Beat contents (lowest bit first)
// -------  ----------------  ---------------------------------------------
// input    in_t*             tdata: time_ticks[31:0]; tuser: waveform[1:0]
// output   out_t*            tdata: sample[15:0], signed
// config   cfg_p*            0x0 phase_step, 0x4 phase_offset, 0x8 amplitude
//
// The block accepts one input beat per clock while the pipeline has room and
// passes it through six register stages to its sample: multiply, offset add,
// quadrant fold, table read, amplitude scale and final select.
// The quarter-wave sine table (1025 entries, Q30) is a constant ROM built at
// elaboration, so no clearing pass is needed after reset.
// Reset clears the stage valid bits and the three registers to zero.
// Stalls on the output let empty stages keep filling; the input is held off
// only when all six stages hold beats and the output beat is not taken.
//
module waveform_sample_generator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,   // time_ticks[31:0]
  input  logic [1:0]                         in_tuser,   // waveform[1:0]
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // sample[15:0]
  // Configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [wsg_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [wsg_pkg::REG_BITS-1:0]       cfg_pwdata,
  output logic [wsg_pkg::REG_BITS-1:0]       cfg_prdata,
  output logic                               cfg_pready
);

  wsg_pkg::cfg_t                  cfg;
  wsg_pkg::pipe_ctl_t             ctl;
  wsg_pkg::ph_out_t               ph_out;
  wsg_pkg::shp_out_t              shp_out;

  logic [wsg_pkg::NSTAGE-1:0]     v_r;
  logic [wsg_pkg::NSTAGE-1:0]     v_nxt;
  logic [wsg_pkg::NSTAGE-1:0]     rdy;
  logic                           in_acc;
  logic                           out_acc;

  wsg_pkg::amp_t                  sin_mag;
  wsg_pkg::amp_t                  mag;
  wsg_pkg::sample_t               mag_c;
  wsg_pkg::sample_t               sample_nxt;
  wsg_pkg::sample_t               sample_r;

  wsg_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // A stage takes a new beat when it is empty or its own beat moves on.
  always_comb begin
    rdy[wsg_pkg::ST_OUT] = !v_r[wsg_pkg::ST_OUT] || out_tready;
    for (int k = wsg_pkg::NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < wsg_pkg::NSTAGE; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctl.ld  = rdy;
  assign ctl.vld = v_r;

  assign in_tready = rdy[wsg_pkg::ST_MUL];
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  wsg_phase u_phase (
    .clk        (clk),
    .ctl        (ctl),
    .cfg        (cfg),
    .time_ticks (in_tdata),
    .waveform   (wsg_pkg::wave_t'(in_tuser)),
    .ph_out     (ph_out)
  );

  wsg_shape u_shape (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .cfg     (cfg),
    .ph_in   (ph_out),
    .shp_out (shp_out)
  );

  // Final stage: round the sine product, pick the shape, clamp the magnitude
  // to the symmetric sample range and apply the half-cycle sign.
  always_comb begin
    sin_mag = wsg_pkg::amp_t'((shp_out.sin_prod + wsg_pkg::SIN_RND) >> wsg_pkg::Q_FRAC);
    unique case (shp_out.wf)
      wsg_pkg::WAVE_SINE:   mag = sin_mag;
      wsg_pkg::WAVE_TRI:    mag = shp_out.tri_mag;
      wsg_pkg::WAVE_SQUARE: mag = cfg.amplitude;
      wsg_pkg::WAVE_ZERO:   mag = '0;
      default:              mag = '0;
    endcase
    if (32'(mag) > 32'(wsg_pkg::SAMPLE_LIM)) begin
      mag_c = wsg_pkg::sample_t'(wsg_pkg::SAMPLE_LIM);
    end else begin
      mag_c = wsg_pkg::sample_t'(mag);
    end
    sample_nxt = shp_out.neg ? -mag_c : mag_c;
  end

  always_ff @(posedge clk) begin
    if (rdy[wsg_pkg::ST_OUT]) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_tvalid = v_r[wsg_pkg::ST_OUT];
  assign out_tdata  = sample_r;

`ifndef SYNTHESIS
  a_no_lost_beats: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) ==
      $past($countones(v_r)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("beat count in the pipeline does not match accepted beats");

  a_hold_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready && (&v_r)))
    else $error("input held off while the pipeline has room");

  a_symmetric_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata != wsg_pkg::SAMPLE_MIN))
    else $error("sample outside the symmetric range");
`endif

endmodule

FILE: dv/waveform_sample_checker.sv
// ----------------------------------------------------------------------------
// Waveform sample checker
// Watches the input, result and configuration ports of the sample generator,
// predicts every sample and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
module waveform_sample_checker
  import wsg_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic                     in_tready,
  input  logic [31:0]              in_tdata,   // time_ticks[31:0]
  input  logic [1:0]               in_tuser,   // waveform[1:0]
  input  logic                     out_tvalid,
  input  logic                     out_tready,
  input  logic [15:0]              out_tdata,  // sample[15:0]
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [REG_BITS-1:0]      cfg_pwdata,
  input  logic                     cfg_pready,
  output int                       outstanding,
  output int                       fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    time_t   ticks;
    wave_t   wf;
    sample_t sample;
  } expected_beat_t;

  expected_beat_t pending_samples[$];

  // Shadow copy of the configuration registers.
  reg_t step_reg;
  reg_t offset_reg;
  amp_t amp_reg;

  logic [Q_FRAC:0] sine_lut [0:TAB_N];

  // Quarter-wave sine in Q30 by a truncated Taylor series, clamped to [0, 1].
  initial begin : build_lut
    logic [63:0] x;
    logic [63:0] term;
    longint      acc;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = (term * x) >> Q_FRAC;
        term = ((term * x) >> Q_FRAC) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > (longint'(1) << Q_FRAC)) begin
        acc = longint'(1) << Q_FRAC;
      end
      sine_lut[k] = acc[Q_FRAC:0];
    end
  end

  function automatic sample_t predict_sample(input time_t ticks, input wave_t wf);
    logic [63:0] quarter;
    logic [63:0] ph;
    logic [63:0] q;
    logic [63:0] idx;
    logic [63:0] mag;
    logic        neg;
    longint      v;
    quarter = 64'd1 << (PHASE_BITS - 2);
    ph  = (64'(ticks) * 64'(step_reg) + 64'(offset_reg)) & ((64'd1 << PHASE_BITS) - 1);
    v   = 0;
    neg = 1'b0;
    case (wf)
      WAVE_SINE: begin
        q = ph & (quarter - 1);
        if (ph[PHASE_BITS-2]) begin
          q = quarter - q;
        end
        idx = (q + (64'd1 << (IDX_SHIFT - 1))) >> IDX_SHIFT;
        if (idx > TAB_N) begin
          idx = TAB_N;
        end
        mag = (64'(amp_reg) * 64'(sine_lut[idx[IDX_BITS-1:0]]) + (64'd1 << (Q_FRAC - 1)))
              >> Q_FRAC;
        v = ph[PHASE_BITS-1] ? -longint'(mag) : longint'(mag);
      end
      WAVE_TRI: begin
        // Quarter points fall on the continuous peak, zero or trough.
        if (ph < quarter) begin
          mag = ph;
        end else if (ph <= 2 * quarter) begin
          mag = 2 * quarter - ph;
        end else if (ph < 3 * quarter) begin
          mag = ph - 2 * quarter;
          neg = 1'b1;
        end else begin
          mag = 4 * quarter - ph;
          neg = 1'b1;
        end
        mag = (64'(amp_reg) * mag + (quarter >> 1)) >> (PHASE_BITS - 2);
        v = neg ? -longint'(mag) : longint'(mag);
      end
      WAVE_SQUARE: begin
        v = (ph < 2 * quarter) ? longint'(amp_reg) : -longint'(amp_reg);
      end
      default: begin
        v = 0;
      end
    endcase
    if (v > SAMPLE_LIM) begin
      v = SAMPLE_LIM;
    end
    if (v < -SAMPLE_LIM) begin
      v = -SAMPLE_LIM;
    end
    return sample_t'(v);
  endfunction

  initial begin
    outstanding = 0;
    fail_count  = 0;
  end

  always @(posedge clk) begin
    expected_beat_t head;
    expected_beat_t fresh;
    if (!rst_n) begin
      pending_samples.delete();
      outstanding = 0;
      step_reg    = '0;
      offset_reg  = '0;
      amp_reg     = '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[CFG_ADDR_BITS-1:2]))
          REG_PHASE_STEP:   step_reg   = cfg_pwdata;
          REG_PHASE_OFFSET: offset_reg = cfg_pwdata;
          REG_AMPLITUDE:    amp_reg    = cfg_pwdata[AMP_BITS-1:0];
          default: ;
        endcase
      end
      // Results are checked before new inputs are added.
      if (out_tvalid && out_tready) begin
        if (pending_samples.size() == 0) begin
          $display("%0t: unexpected result beat: expected none, actual %0d",
                   $time, $signed(out_tdata));
          fail_count++;
        end else begin
          head = pending_samples.pop_front();
          if (out_tdata !== head.sample) begin
            $display("%0t: sample mismatch (time_ticks %h, %s): expected %0d, actual %0d",
                     $time, head.ticks, head.wf.name(), head.sample, $signed(out_tdata));
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fresh.ticks  = in_tdata;
        fresh.wf     = wave_t'(in_tuser);
        fresh.sample = predict_sample(in_tdata, wave_t'(in_tuser));
        pending_samples.push_back(fresh);
      end
      outstanding = pending_samples.size();
    end
  end

endmodule

FILE: dv/waveform_sample_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// Waveform sample generator testbench
// Drives time and waveform beats and register writes into the generator,
// with random idle bursts on both streams, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module waveform_sample_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsg_pkg::*;

  // Generous bound on the whole run, far above the slowest legal schedule.
  localparam int CYCLE_LIMIT   = 200000;
  // Six pipeline stages; the settle wait leaves margin on top.
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BEATS   = 105;
  // Address slot past the last register; writes there must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [31:0]              in_tdata = '0;   // time_ticks[31:0]
  logic [1:0]               in_tuser = '0;   // waveform[1:0]
  logic                     out_tvalid;
  logic                     out_tready = 1'b1;
  logic [15:0]              out_tdata;       // sample[15:0]
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [REG_BITS-1:0]      cfg_pwdata = '0;
  logic [REG_BITS-1:0]      cfg_prdata;
  logic                     cfg_pready;

  int outstanding;
  int fail_count;
  int cycle_count;
  int stall_left = 0;
  // When clear, neither the sender nor the receiver inserts idle cycles.
  logic idling_on = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  waveform_sample_generator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  waveform_sample_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Receiver back-pressure: random stall bursts of random length. The
  // single nonblocking write per falling edge keeps tready glitch free.
  always @(negedge clk) begin
    if (!rst_n || !idling_on) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Presents one input beat, after an optional idle burst. It is entered and
  // left at a falling edge, and tvalid stays high so that back-to-back beats
  // form a continuous stream; the next idle burst or drain lowers it.
  task automatic send_beat(input time_t ticks, input wave_t wf);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = ticks;
    in_tuser  = wf;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted sample has come back, then
  // lets the pipeline settle so a register write cannot meet a live beat.
  task automatic drain_pipeline();
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write: setup cycle, then the access cycle.
  task automatic cfg_write(input logic [1:0] idx, input reg_t value);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  initial begin : stimulus
    reg_t  step_val;
    reg_t  offset_val;
    reg_t  amp_val;
    time_t ticks;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Registers at their reset value: every waveform must come out as zero.
    for (int w = 0; w < 4; w++) begin
      send_beat($urandom, wave_t'(w));
    end

    // A step of a quarter cycle lands exactly on the quadrant boundaries, so
    // each waveform is seen at zero, peak, midpoint and trough phases with
    // the largest amplitude. The all-ones time wraps back to three quarters.
    drain_pipeline();
    cfg_write(REG_PHASE_STEP, 32'h4000_0000);
    cfg_write(REG_PHASE_OFFSET, 32'h0000_0000);
    cfg_write(REG_AMPLITUDE, 32'h0000_7FFF);
    for (int t = 0; t < 4; t++) begin
      for (int w = 0; w < 4; w++) begin
        send_beat(time_t'(t), wave_t'(w));
      end
    end
    send_beat(32'hFFFF_FFFF, WAVE_SINE);
    send_beat(32'hFFFF_FFFF, WAVE_TRI);

    // All-ones step and offset make the phase wrap through zero. Upper bits
    // of the amplitude write must be dropped, and the spare slot ignored.
    drain_pipeline();
    cfg_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
    cfg_write(REG_PHASE_OFFSET, 32'hFFFF_FFFF);
    cfg_write(REG_AMPLITUDE, 32'hFFFF_0001);
    cfg_write(REG_SPARE, 32'hFFFF_FFFF);
    send_beat(32'h0000_0000, WAVE_SINE);
    send_beat(32'h0000_0001, WAVE_TRI);
    send_beat(32'hFFFF_FFFF, WAVE_SQUARE);
    send_beat(32'hFFFF_FFFF, WAVE_SINE);
    send_beat(32'h0000_0000, WAVE_SQUARE);
    send_beat(32'h8000_0000, WAVE_ZERO);

    // Random phases, each with its own register setting. The last two run
    // with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_pipeline();
      idling_on = (p < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       step_val = 32'h0000_0000;
        1:       step_val = 32'h0000_0001;
        2:       step_val = 32'hFFFF_FFFF;
        3:       step_val = 32'h1 << $urandom_range(0, 31);
        4:       step_val = $urandom_range(1, 65535);
        default: step_val = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0:       offset_val = 32'h0000_0000;
        1:       offset_val = 32'hFFFF_FFFF;
        default: offset_val = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0:       amp_val = 32'h0000_7FFF;
        1:       amp_val = 32'h0000_0001;
        2:       amp_val = 32'h0000_0000;
        3:       amp_val = $urandom_range(0, 32767);
        default: amp_val = $urandom;
      endcase
      cfg_write(REG_PHASE_STEP, step_val);
      cfg_write(REG_PHASE_OFFSET, offset_val);
      cfg_write(REG_AMPLITUDE, amp_val);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(REG_SPARE, $urandom);
      end
      ticks = $urandom;
      for (int i = 0; i < PHASE_BEATS; i++) begin
        // Mostly random times, with runs of consecutive ticks as a sweep.
        if ($urandom_range(0, 3) == 0) begin
          ticks = ticks + 1;
        end else begin
          ticks = $urandom;
        end
        send_beat(ticks, wave_t'($urandom_range(0, 3)));
        // Mid-phase, the sender once waits for the pipeline to empty.
        if (p == 3 && i == PHASE_BEATS / 2) begin
          drain_pipeline();
        end
      end
    end

    drain_pipeline();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
